/* src/low_power_entry_sequencer_assert.svh */
// -----------------------------------------------------------------------------
// Low-power entry sequencer assertion macros
// Property macros used by the sequencer; define NO_ASSERTIONS to drop them.
// -----------------------------------------------------------------------------
`ifndef LOW_POWER_ENTRY_SEQUENCER_ASSERT_SVH
`define LOW_POWER_ENTRY_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define LPES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled during reset.
`define LPES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`else

`define LPES_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LPES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/lpes_pkg.sv */
// -----------------------------------------------------------------------------
// Low-power entry sequencer package
// Shared types, codes, reset values and a helper function.
// -----------------------------------------------------------------------------
package lpes_pkg;

    localparam int ACK_BITS_DEF = 8;
    localparam int ACK_IN_W     = 8;

    localparam logic [15:0] PERIOD_RESET = 16'd15000;
    localparam logic [7:0]  MASK_RESET   = 8'hFF;
    localparam logic [7:0]  COUNT_MAX    = 8'hFF;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_GAME_ENTER = 4'd1,
        OP_GAME_EXIT  = 4'd2,
        OP_AUDIO_ON   = 4'd3,
        OP_AUDIO_OFF  = 4'd4,
        OP_DEBUG_ON   = 4'd5,
        OP_DEBUG_OFF  = 4'd6,
        OP_STREAM_ON  = 4'd7,
        OP_STREAM_OFF = 4'd8,
        OP_INACTIVITY = 4'd9,
        OP_ACTIVITY   = 4'd10,
        OP_SLEEP_REQ  = 4'd11,
        OP_ACK_SET    = 4'd12,
        OP_ACK_CLEAR  = 4'd13,
        OP_POLL       = 4'd14
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_GAME_SLEEP = 2'd0,
        CFG_PERIOD     = 2'd1,
        CFG_ACK_MASK   = 2'd2,
        CFG_DEBUG_INIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        game_sleep_allowed;
        logic [15:0] period;
        logic [7:0]  ack_mask;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  ack_bits;
        logic        audio_active;
        logic        display_busy;
        logic        storage_busy;
    } t_item;

    typedef struct packed {
        logic [7:0]  audio_refs;
        logic [7:0]  debug_refs;
        logic [7:0]  stream_refs;
        logic        pending;
        logic        in_game;
        logic        quiesce;
        logic [15:0] countdown;
    } t_state;

    // A zero period reloads as one millisecond.
    function automatic logic [15:0] reload_value(input logic [15:0] period);
        return (period == 16'd0) ? 16'd1 : period;
    endfunction

endpackage

/* src/low_power_entry_sequencer.sv */
// -----------------------------------------------------------------------------
// Low-power entry sequencer
// Tracks system events and decides when the device may enter stop mode.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: one event item per accepted transfer (i_in_valid high and
//   o_in_stall low at a rising edge): opcode, ack bits and the audio, display
//   and storage busy levels sampled with the event.
//   Output channel: exactly one result item per event, in order: the sleep
//   entry pulse plus a snapshot of quiesce, debug, game mode, pending sleep and
//   the audio and stream reference counts.
//   The input register takes the item at the accepting edge; the result
//   register is loaded after one pass of event logic and sleep gate, once
//   it can advance (it is empty or its result is being taken).
//   Throughput: one item per cycle while the result channel does not stall;
//   the state update for an item completes as it moves from the input
//   register to the result register, so the next item sees it immediately.
//   A stalled result holds in the result register; one more item waits in
//   the input register, and only then is o_in_stall raised.
//   Reset (synchronous, active low) clears both channels, restores register
//   defaults and reloads the inactivity countdown. Write configuration only
//   while no item is in flight.
// -----------------------------------------------------------------------------
`include "low_power_entry_sequencer_assert.svh"

module low_power_entry_sequencer #(
    parameter int ACK_BITS = lpes_pkg::ACK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_ack_bits,
    input  logic        i_audio_active,
    input  logic        i_display_busy,
    input  logic        i_storage_busy,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_enter_sleep,
    output logic        o_quiesce_request,
    output logic        o_debug_mode,
    output logic        o_game_mode,
    output logic        o_sleep_pending_out,
    output logic [7:0]  o_audio_count,
    output logic [7:0]  o_stream_count
);

    lpes_pkg::t_cfg      cfg;

    // Input register.
    logic                r_in_valid;
    lpes_pkg::t_item     r_in;

    // Sequencer state.
    lpes_pkg::t_state    r_state;
    logic [ACK_BITS-1:0] r_ack;

    // Result register.
    logic                r_out_valid;
    logic                r_enter_sleep;
    lpes_pkg::t_state    r_out_state;

    lpes_pkg::t_state    ev_state;
    logic [ACK_BITS-1:0] ev_ack;
    lpes_pkg::t_state    n_state;
    logic [ACK_BITS-1:0] n_ack;
    logic                n_slept;

    logic                out_adv;
    logic                step_fire;
    logic                in_accept;
    logic                debug_init_wr;

    // Advance the result register when it is empty or being taken.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign step_fire  = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Writing debug_at_start as one raises a zero debug count to one, unless an item steps at the same time.
    assign debug_init_wr = i_cfg_we
                        && (lpes_pkg::t_cfg_idx'(i_cfg_index) == lpes_pkg::CFG_DEBUG_INIT)
                        && i_cfg_wdata[0];

    lpes_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lpes_event #(.ACK_BITS(ACK_BITS)) u_event (
        .i_state (r_state),
        .i_ack   (r_ack),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_state (ev_state),
        .o_ack   (ev_ack)
    );

    lpes_gate #(.ACK_BITS(ACK_BITS)) u_gate (
        .i_state (ev_state),
        .i_ack   (ev_ack),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_ack   (n_ack),
        .o_slept (n_slept)
    );

    // Control: valid flags and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.audio_refs  <= 8'd0;
            r_state.debug_refs  <= 8'd0;
            r_state.stream_refs <= 8'd0;
            r_state.pending     <= 1'b0;
            r_state.in_game     <= 1'b0;
            r_state.quiesce     <= 1'b0;
            r_state.countdown   <= lpes_pkg::PERIOD_RESET;
            r_ack               <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
                r_ack   <= n_ack;
            end else if (debug_init_wr && (r_state.debug_refs == 8'd0)) begin
                r_state.debug_refs <= 8'd1;
            end
        end
    end

    // Payload: capture the event, then the result snapshot.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.opcode       <= i_opcode;
            r_in.ack_bits     <= i_ack_bits;
            r_in.audio_active <= i_audio_active;
            r_in.display_busy <= i_display_busy;
            r_in.storage_busy <= i_storage_busy;
        end
        if (step_fire) begin
            r_enter_sleep <= n_slept;
            r_out_state   <= n_state;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_enter_sleep       = r_enter_sleep;
    assign o_quiesce_request   = r_out_state.quiesce;
    assign o_debug_mode        = (r_out_state.debug_refs != 8'd0);
    assign o_game_mode         = r_out_state.in_game;
    assign o_sleep_pending_out = r_out_state.pending;
    assign o_audio_count       = r_out_state.audio_refs;
    assign o_stream_count      = r_out_state.stream_refs;

    // A quiesce request only exists while sleep is pending.
    `LPES_ASSERT_NOW(a_quiesce_pending, i_clk, i_rst_n, r_state.quiesce, r_state.pending)
    // Sleep entry clears quiesce and pending in the same result.
    `LPES_ASSERT_NOW(a_sleep_clears, i_clk, i_rst_n, o_out_valid && o_enter_sleep,
                     !o_quiesce_request && !o_sleep_pending_out)
    // Input side stalls only behind a held, full result register.
    `LPES_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
                     r_in_valid && r_out_valid && i_out_stall)
    // A processed item always lands in the result register.
    `LPES_ASSERT_NEXT(a_step_lands, i_clk, i_rst_n, step_fire, o_out_valid)

endmodule

/* src/lpes_cfg.sv */
// -----------------------------------------------------------------------------
// Low-power entry sequencer configuration registers
// Holds sleep permission, inactivity period and required acknowledge mask.
// -----------------------------------------------------------------------------
module lpes_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    output lpes_pkg::t_cfg       o_cfg
);

    lpes_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.game_sleep_allowed <= 1'b1;
            r_cfg.period             <= lpes_pkg::PERIOD_RESET;
            r_cfg.ack_mask           <= lpes_pkg::MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (lpes_pkg::t_cfg_idx'(i_cfg_index))
                lpes_pkg::CFG_GAME_SLEEP: r_cfg.game_sleep_allowed <= i_cfg_wdata[0];
                lpes_pkg::CFG_PERIOD:     r_cfg.period             <= i_cfg_wdata;
                lpes_pkg::CFG_ACK_MASK:   r_cfg.ack_mask           <= i_cfg_wdata[7:0];
                default: ;  // debug start count is applied to the state directly
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/lpes_event.sv */
// -----------------------------------------------------------------------------
// Low-power entry sequencer event decoder
// Applies one event to the sequencer state ahead of the sleep gate.
// -----------------------------------------------------------------------------
module lpes_event #(
    parameter int ACK_BITS = lpes_pkg::ACK_BITS_DEF
) (
    input  lpes_pkg::t_state     i_state,
    input  logic [ACK_BITS-1:0]  i_ack,
    input  lpes_pkg::t_item      i_item,
    input  lpes_pkg::t_cfg       i_cfg,
    output lpes_pkg::t_state     o_state,
    output logic [ACK_BITS-1:0]  o_ack
);

    localparam int EXT_W = (ACK_BITS > lpes_pkg::ACK_IN_W) ? ACK_BITS : lpes_pkg::ACK_IN_W;

    logic [EXT_W-1:0]    ack_ext;
    logic [ACK_BITS-1:0] bits;

    // Drop ack bits above the implemented width.
    assign ack_ext = EXT_W'(i_item.ack_bits);
    assign bits    = ack_ext[ACK_BITS-1:0];

    function automatic logic [7:0] count_up(input logic [7:0] v);
        return (v != lpes_pkg::COUNT_MAX) ? v + 8'd1 : v;
    endfunction

    function automatic logic [7:0] count_down(input logic [7:0] v);
        return (v != 8'd0) ? v - 8'd1 : v;
    endfunction

    always_comb begin
        o_state = i_state;
        o_ack   = i_ack;
        unique case (lpes_pkg::t_opcode'(i_item.opcode)) inside
            lpes_pkg::OP_TICK: begin
                if (i_state.countdown != 16'd0) begin
                    o_state.countdown = i_state.countdown - 16'd1;
                    if (i_state.countdown == 16'd1) begin
                        o_state.pending = 1'b1;
                    end
                end
            end
            lpes_pkg::OP_GAME_ENTER: o_state.in_game     = 1'b1;
            lpes_pkg::OP_GAME_EXIT:  o_state.in_game     = 1'b0;
            lpes_pkg::OP_AUDIO_ON:   o_state.audio_refs  = count_up(i_state.audio_refs);
            lpes_pkg::OP_AUDIO_OFF:  o_state.audio_refs  = count_down(i_state.audio_refs);
            lpes_pkg::OP_DEBUG_ON:   o_state.debug_refs  = count_up(i_state.debug_refs);
            lpes_pkg::OP_DEBUG_OFF:  o_state.debug_refs  = count_down(i_state.debug_refs);
            lpes_pkg::OP_STREAM_ON:  o_state.stream_refs = count_up(i_state.stream_refs);
            lpes_pkg::OP_STREAM_OFF: o_state.stream_refs = count_down(i_state.stream_refs);
            lpes_pkg::OP_INACTIVITY, lpes_pkg::OP_SLEEP_REQ: o_state.pending = 1'b1;
            lpes_pkg::OP_ACTIVITY: begin
                o_state.pending   = 1'b0;
                o_state.countdown = lpes_pkg::reload_value(i_cfg.period);
                if (i_state.quiesce) begin
                    o_state.quiesce = 1'b0;
                    o_ack           = '0;
                end
            end
            lpes_pkg::OP_ACK_SET:   o_ack = i_ack | bits;
            lpes_pkg::OP_ACK_CLEAR: o_ack = i_ack & ~bits;
            default: ;  // poll and the unused code only run the gate
        endcase
    end

endmodule

/* src/lpes_gate.sv */
// -----------------------------------------------------------------------------
// Low-power entry sequencer sleep gate
// Checks permission, audio, quiesce, acknowledges, display and storage in order.
// -----------------------------------------------------------------------------
module lpes_gate #(
    parameter int ACK_BITS = lpes_pkg::ACK_BITS_DEF
) (
    input  lpes_pkg::t_state     i_state,
    input  logic [ACK_BITS-1:0]  i_ack,
    input  lpes_pkg::t_item      i_item,
    input  lpes_pkg::t_cfg       i_cfg,
    output lpes_pkg::t_state     o_state,
    output logic [ACK_BITS-1:0]  o_ack,
    output logic                 o_slept
);

    localparam int EXT_W = (ACK_BITS > lpes_pkg::ACK_IN_W) ? ACK_BITS : lpes_pkg::ACK_IN_W;

    logic [EXT_W-1:0]    mask_ext;
    logic [ACK_BITS-1:0] need;
    logic [ACK_BITS-1:0] ack_q;

    assign mask_ext = EXT_W'(i_cfg.ack_mask);
    assign need     = mask_ext[ACK_BITS-1:0];

    // Raising the quiesce request starts from a clean set of acks.
    assign ack_q = i_state.quiesce ? i_ack : '0;

    always_comb begin
        o_state = i_state;
        o_ack   = i_ack;
        o_slept = 1'b0;
        if (i_state.pending) begin
            if (!i_cfg.game_sleep_allowed && i_state.in_game) begin
                // Mode forbids sleep: drop the request as on activity.
                o_state.pending   = 1'b0;
                o_state.countdown = lpes_pkg::reload_value(i_cfg.period);
                if (i_state.quiesce) begin
                    o_state.quiesce = 1'b0;
                    o_ack           = '0;
                end
            end else if (!i_item.audio_active) begin
                o_state.quiesce = 1'b1;
                o_ack           = ack_q;
                if (((ack_q & need) == need) && !i_item.display_busy
                        && !i_item.storage_busy) begin
                    o_slept           = 1'b1;
                    o_state.pending   = 1'b0;
                    o_state.quiesce   = 1'b0;
                    o_state.countdown = lpes_pkg::reload_value(i_cfg.period);
                    o_ack             = '0;
                end
            end
        end
    end

endmodule
